>>> hdl/rgbcb_pkg.sv
`default_nettype none

package rgbcb_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CONTRAST   = 2'd0,
    CFG_BRIGHTNESS = 2'd1,
    CFG_DETAIL     = 2'd2
  } cfg_index_t;

  localparam int NUM_CH = 3;  // blue, green, red

  // Gain g is (600 - detail) * (100 + contrast); the product is scaled by 1/50000
  localparam logic [9:0]  DETAIL_BASE   = 10'd600;
  localparam logic [7:0]  CONTRAST_BASE = 8'd100;
  localparam logic [7:0]  MID_GREY      = 8'd128;
  localparam logic [15:0] DIVISOR       = 16'd50000;
  localparam logic [14:0] HALF_DIVISOR  = 15'd25000;

  // Numerator at or above 256 * 50000 saturates to 255
  localparam logic [24:0] SAT_LIMIT = 25'd12800000;
  localparam logic [7:0]  PIX_MAX   = 8'd255;

  // floor(n / 50000) = floor((n >> 4) / 3125) = ((n >> 4) * RECIP) >> RECIP_SHIFT,
  // exact for (n >> 4) < 2^20
  localparam logic [20:0] RECIP       = 21'd1374390;
  localparam int          RECIP_SHIFT = 32;

endpackage

`default_nettype wire

>>> hdl/rgb565_contrast_brightness_unit.sv
// An accepted input transaction passes through the four register stages in order
// to become its output transaction; m_tvalid is the valid flag of the last stage.
// Throughput: one pixel per clock unless m_tready stalls; the four register stages
// advance independently, so a bubble is squeezed out and a stall at m_tready
// back-pressures stage by stage. Settings written on the cfg channel reach the
// datapath through the setting registers and then the gain and offset registers.
// Reset (rst, synchronous) empties the pipeline and sets contrast, brightness, detail to 0.
`default_nettype none

module rgb565_contrast_brightness_unit
  import rgbcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input pixel stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] pixel_in
  input  wire logic        s_tlast,   // last_pixel
  // output pixel stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] pixel_out
  output logic             m_tlast,   // end_of_frame
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  // ------------------------------------------------------------------
  // Configuration registers and derived gain / offset
  // ------------------------------------------------------------------
  logic [6:0]  contrast;
  logic [6:0]  brightness;
  logic [6:0]  detail;
  logic [16:0] gain;       // (600 - detail) * (100 + contrast), 17028..97800
  logic [23:0] offset;     // (brightness + 128) * 50000 + 25000

  logic [9:0]  detail_factor;
  logic [7:0]  contrast_factor;
  logic [7:0]  bias;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast   <= '0;
      brightness <= '0;
      detail     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONTRAST:   contrast   <= cfg_data;
        CFG_BRIGHTNESS: brightness <= cfg_data;
        CFG_DETAIL:     detail     <= cfg_data;
        default:        ;  // drop writes to unused indexes
      endcase
    end
  end

  // 8-bit wraparound sums give 36..163 and 64..191 for any 7-bit signed setting
  assign detail_factor   = DETAIL_BASE - {3'b000, detail};
  assign contrast_factor = CONTRAST_BASE + {contrast[6], contrast};
  assign bias            = MID_GREY + {brightness[6], brightness};

  // Gain and offset depend only on the settings; register them off the pixel path
  always_ff @(posedge clk) begin
    gain   <= 17'(detail_factor * contrast_factor);
    offset <= 24'(bias * DIVISOR) + 24'(HALF_DIVISOR);
  end

  // ------------------------------------------------------------------
  // Pipeline control: each stage takes new data when it is empty or its
  // successor takes its content.
  // ------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: widen each channel to 8 bits and subtract mid-grey.
  // v - 128 is v with its top bit inverted, read as signed.
  // ------------------------------------------------------------------
  logic signed [7:0] s1_dev [NUM_CH];
  logic              s1_last;
  logic [7:0]        wide   [NUM_CH];

  assign wide[0] = {s_tdata[4:0],   3'b000};  // blue
  assign wide[1] = {s_tdata[10:5],  2'b00};   // green
  assign wide[2] = {s_tdata[15:11], 3'b000};  // red

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s1_dev[c] <= $signed({~wide[c][7], wide[c][6:0]});
      end
      s1_last <= s_tlast;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: scale the deviation by the gain
  // ------------------------------------------------------------------
  logic signed [25:0] s2_prod [NUM_CH];
  logic               s2_last;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s2_prod[c] <= s1_dev[c] * $signed({1'b0, gain});
      end
      s2_last <= s1_last;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: add offset and rounding half, flag the clamp cases
  // ------------------------------------------------------------------
  logic signed [25:0] num    [NUM_CH];
  logic [19:0]        s3_num [NUM_CH];  // numerator / 16
  logic               s3_neg [NUM_CH];
  logic               s3_sat [NUM_CH];
  logic               s3_last;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num[c] = s2_prod[c] + $signed({2'b00, offset});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s3_num[c] <= num[c][23:4];
        s3_neg[c] <= num[c][25];
        s3_sat[c] <= !num[c][25] && (num[c][24:0] >= SAT_LIMIT);
      end
      s3_last <= s2_last;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4 (output register): divide by 50000 via reciprocal, clamp, narrow
  // ------------------------------------------------------------------
  logic [40:0] quot_wide [NUM_CH];
  logic [7:0]  mapped    [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      quot_wide[c] = s3_num[c] * RECIP;
      if (s3_neg[c]) begin
        mapped[c] = '0;
      end else if (s3_sat[c]) begin
        mapped[c] = PIX_MAX;
      end else begin
        mapped[c] = quot_wide[c][RECIP_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      m_tdata <= {mapped[2][7:3], mapped[1][7:2], mapped[0][7:3]};
      m_tlast <= s3_last;
    end
  end

  assign m_tvalid = v4;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  // Input back-pressure only when every stage is full and the sink stalls
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && !m_tready))
    else $error("input stalled with a free pipeline stage");

  // An accepted transaction always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted pixel not captured");

  // A numerator cannot be both negative and saturating
  a_clamp_exclusive: assert property (@(posedge clk) disable iff (rst)
    v3 |-> !((s3_neg[0] && s3_sat[0]) || (s3_neg[1] && s3_sat[1]) ||
             (s3_neg[2] && s3_sat[2])))
    else $error("conflicting clamp flags");

endmodule

`default_nettype wire
